/* hw/rtl/stp_pkg.sv */
// Shared constants and types of the software timer pool.
package stp_pkg;

  // Command codes carried by the command field.
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CREATE  = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;
  localparam logic [2:0] CMD_CHECK   = 3'd5;

  // Slot status codes.
  localparam logic [1:0] ST_FREE      = 2'd0;
  localparam logic [1:0] ST_SUSPENDED = 2'd1;
  localparam logic [1:0] ST_RUNNING   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT   = 2'd3;

  localparam int unsigned NUM_SLOTS_DEF = 32;
  localparam int unsigned MAX_RESULTS   = 32;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam logic [7:0]  TPS_RESET     = 8'd10;

  typedef enum logic [1:0] {
    ALU_ADD_DUR,
    ALU_INC,
    ALU_CMP
  } stp_alu_op_e;

  typedef struct packed {
    logic [1:0]  status;
    logic        notify;
    logic [63:0] deadline;
  } stp_entry_t;

  typedef struct packed {
    logic [4:0] slot;
    logic       success;
    logic [1:0] status;
    logic       expiry;
    logic       second;
    logic       last;
  } stp_result_t;

endpackage

/* hw/rtl/stp_alu.sv */
// Shared 64-bit adder used for deadline sums, the seconds increment and deadline compares.
module stp_alu (
  input  stp_pkg::stp_alu_op_e op_i,
  input  logic [63:0]          now_i,
  input  logic [31:0]          dur_i,
  input  logic [63:0]          deadline_i,
  output logic [63:0]          sum_o,
  output logic                 ge_o
);

  logic [63:0] b_op;
  logic        cin;
  logic [64:0] sum;

  always_comb begin
    unique case (op_i)
      stp_pkg::ALU_ADD_DUR: begin
        b_op = {32'b0, dur_i};
        cin  = 1'b0;
      end
      stp_pkg::ALU_INC: begin
        b_op = 64'b0;
        cin  = 1'b1;
      end
      default: begin
        // now - deadline: carry out set when now >= deadline.
        b_op = ~deadline_i;
        cin  = 1'b1;
      end
    endcase
  end

  assign sum   = {1'b0, now_i} + {1'b0, b_op} + {64'b0, cin};
  assign sum_o = sum[63:0];
  assign ge_o  = sum[64];

endmodule

/* hw/rtl/stp_slot_mem.sv */
// Slot table memory: status, notify flag and deadline per slot, one write and one read port.
module stp_slot_mem #(
  parameter int unsigned NUM_SLOTS = stp_pkg::NUM_SLOTS_DEF,
  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  stp_pkg::stp_entry_t wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output stp_pkg::stp_entry_t rdata_o
);

  stp_pkg::stp_entry_t mem_q [NUM_SLOTS];
  stp_pkg::stp_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/software_timer_pool_top.sv */
// Top level of the software timer pool: sequencer, seconds base, slot valid bits, output register.
//
// The block keeps NUM_SLOTS one-shot timers that count whole seconds.
// Items enter on the input channel (in_valid_i / in_stall_o) and carry a
// command: tick, create, start, suspend, query or check. Results leave on the
// output channel (out_valid_o / out_stall_i) through a single output register.
// Every command gives one result; check gives one result per reported expiry
// (at most MAX_RESULTS) or one empty result, last_result marking the final one.
// One item at a time: the input stalls until the item's final result is loaded.
// With the output free, tick, unknown commands and refused start, suspend or
// query are answered from the execute state; a valid start, suspend or query
// first reads the memory, then writes back and answers. Create scans the
// slot valid bits one slot per cycle until it finds a free slot or reaches the last.
// Check streams the slot memory one slot per cycle through the shared 64-bit
// adder and the memory's single read port, pausing while a report waits for the output.
// A stalled receiver holds the output register; the sequencer then waits at
// its next result, so no result is lost or repeated.
// Reset clears the seconds counter, prescaler and the slot valid bits, so
// every slot reads as free at once; no clearing pass is needed. The
// configuration channel (cfg_valid_i / cfg_ready_o) writes ticks per second and is always ready;
// the user must write it only while the block is idle; the block itself does not enforce this.
module software_timer_pool_top #(
  parameter int unsigned NUM_SLOTS = stp_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: ticks per second.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Input items.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [4:0]  target_slot_i,
  input  logic [31:0] duration_i,
  input  logic        notify_on_expiry_i,
  // Result items.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  result_slot_o,
  output logic        success_o,
  output logic [1:0]  slot_status_o,
  output logic        expiry_report_o,
  output logic        second_event_o,
  output logic        last_result_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_RMW  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_CEND = 3'd5;

  logic [2:0] state_q, state_d;

  // Latched item.
  logic [2:0]  cmd_q;
  logic [4:0]  tgt_q;
  logic [31:0] dur_q;
  logic        notify_q;

  // Timekeeping and slot bookkeeping.
  logic [7:0]           tps_q, tps_d;
  logic [7:0]           presc_q, presc_d;
  logic [63:0]          now_q, now_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [IdxW-1:0]      idx_q, idx_d;

  // Pending expiry report held back until it is known whether it is the last.
  logic                    pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]         pend_slot_q, pend_slot_d;
  logic [stp_pkg::CNT_W-1:0] rep_cnt_q, rep_cnt_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  stp_pkg::stp_result_t out_res_q, out_res_d;
  logic                 out_free;
  logic                 emit;
  stp_pkg::stp_result_t emit_res;

  // Memory and shared adder.
  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      mem_waddr, mem_raddr;
  stp_pkg::stp_entry_t  mem_wdata, rd_entry;
  stp_pkg::stp_alu_op_e alu_op;
  logic [63:0]          alu_sum;
  logic                 alu_ge;

  logic            in_acc;
  logic [IdxW+4:0] tgt_wide, idx_wide, pend_wide;
  logic [IdxW-1:0] tgt_idx;
  logic            tgt_ok;
  logic [8:0]      presc_inc;
  logic            tick_sec;
  logic            chk_hit, chk_report, chk_block;

  stp_slot_mem #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slot_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rd_entry)
  );

  stp_alu u_alu (
    .op_i      (alu_op),
    .now_i     (now_q),
    .dur_i     (dur_q),
    .deadline_i(rd_entry.deadline),
    .sum_o     (alu_sum),
    .ge_o      (alu_ge)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // A target beyond the pool behaves like a free slot.
  assign tgt_wide  = (IdxW + 5)'(tgt_q);
  assign tgt_idx   = tgt_wide[IdxW-1:0];
  assign tgt_ok    = (tgt_wide < (IdxW + 5)'(NUM_SLOTS)) && valid_q[tgt_idx];
  assign idx_wide  = (IdxW + 5)'(idx_q);
  assign pend_wide = (IdxW + 5)'(pend_slot_q);

  // A tick completes a second when the prescaler plus one reaches the ticks-per-second limit.
  assign presc_inc = {1'b0, presc_q} + 9'd1;
  assign tick_sec  = presc_inc >= {1'b0, tps_q};

  // Check: the running slot under the read pointer has reached its deadline.
  assign chk_hit    = valid_q[idx_q] && (rd_entry.status == stp_pkg::ST_RUNNING) && alu_ge;
  assign chk_report = chk_hit && rd_entry.notify &&
                      (rep_cnt_q < stp_pkg::CNT_W'(stp_pkg::MAX_RESULTS));
  assign chk_block  = chk_report && pend_valid_q && !out_free;

  always_comb begin
    tps_d = tps_q;
    if (cfg_valid_i && cfg_ready_o) begin
      tps_d = cfg_data_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    presc_d      = presc_q;
    now_d        = now_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    rep_cnt_d    = rep_cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_entry;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    alu_op       = stp_pkg::ALU_CMP;
    emit         = 1'b0;
    emit_res     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (cmd_q)
          stp_pkg::CMD_TICK: begin
            alu_op = stp_pkg::ALU_INC;
            if (out_free) begin
              presc_d = tick_sec ? 8'd0 : presc_inc[7:0];
              if (tick_sec) begin
                now_d = alu_sum;
              end
              emit            = 1'b1;
              emit_res.success = 1'b1;
              emit_res.second  = tick_sec;
              emit_res.last    = 1'b1;
              state_d          = S_IDLE;
            end
          end
          stp_pkg::CMD_CREATE: begin
            idx_d   = '0;
            state_d = S_FIND;
          end
          stp_pkg::CMD_START, stp_pkg::CMD_SUSPEND, stp_pkg::CMD_QUERY: begin
            if (tgt_ok) begin
              mem_re    = 1'b1;
              mem_raddr = tgt_idx;
              state_d   = S_RMW;
            end else if (out_free) begin
              emit          = 1'b1;
              emit_res.slot = tgt_q;
              emit_res.last = 1'b1;
              state_d       = S_IDLE;
            end
          end
          stp_pkg::CMD_CHECK: begin
            mem_re       = 1'b1;
            mem_raddr    = '0;
            idx_d        = '0;
            pend_valid_d = 1'b0;
            rep_cnt_d    = '0;
            state_d      = S_CHK;
          end
          default: begin
            if (out_free) begin
              emit          = 1'b1;
              emit_res.last = 1'b1;
              state_d       = S_IDLE;
            end
          end
        endcase
      end

      S_FIND: begin
        alu_op = stp_pkg::ALU_ADD_DUR;
        if (!valid_q[idx_q]) begin
          if (out_free) begin
            mem_we             = 1'b1;
            mem_waddr          = idx_q;
            mem_wdata.status   = stp_pkg::ST_SUSPENDED;
            mem_wdata.notify   = notify_q;
            mem_wdata.deadline = alu_sum;
            valid_d[idx_q]     = 1'b1;
            emit               = 1'b1;
            emit_res.slot      = idx_wide[4:0];
            emit_res.success   = 1'b1;
            emit_res.status    = stp_pkg::ST_SUSPENDED;
            emit_res.last      = 1'b1;
            state_d            = S_IDLE;
          end
        end else if (idx_q == LastIdx) begin
          // Pool full.
          if (out_free) begin
            emit          = 1'b1;
            emit_res.last = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_RMW: begin
        alu_op = stp_pkg::ALU_ADD_DUR;
        if (out_free) begin
          mem_waddr        = tgt_idx;
          emit             = 1'b1;
          emit_res.slot    = tgt_q;
          emit_res.success = 1'b1;
          emit_res.last    = 1'b1;
          unique case (cmd_q)
            stp_pkg::CMD_START: begin
              mem_we             = 1'b1;
              mem_wdata.status   = stp_pkg::ST_RUNNING;
              mem_wdata.deadline = alu_sum;
              emit_res.status    = stp_pkg::ST_RUNNING;
            end
            stp_pkg::CMD_SUSPEND: begin
              mem_we           = 1'b1;
              mem_wdata.status = stp_pkg::ST_SUSPENDED;
              emit_res.status  = stp_pkg::ST_SUSPENDED;
            end
            default: begin
              emit_res.status = rd_entry.status;
            end
          endcase
          state_d = S_IDLE;
        end
      end

      S_CHK: begin
        alu_op = stp_pkg::ALU_CMP;
        if (!chk_block) begin
          if (chk_hit) begin
            mem_we           = 1'b1;
            mem_waddr        = idx_q;
            mem_wdata.status = stp_pkg::ST_TIMEOUT;
          end
          if (chk_report) begin
            if (pend_valid_q) begin
              emit             = 1'b1;
              emit_res.slot    = pend_wide[4:0];
              emit_res.success = 1'b1;
              emit_res.status  = stp_pkg::ST_TIMEOUT;
              emit_res.expiry  = 1'b1;
            end
            pend_valid_d = 1'b1;
            pend_slot_d  = idx_q;
            rep_cnt_d    = rep_cnt_q + 1'b1;
          end
          if (idx_q == LastIdx) begin
            state_d = S_CEND;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_q + 1'b1;
            idx_d     = idx_q + 1'b1;
          end
        end
      end

      S_CEND: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_res.success = 1'b1;
          emit_res.last    = 1'b1;
          if (pend_valid_q) begin
            emit_res.slot   = pend_wide[4:0];
            emit_res.status = stp_pkg::ST_TIMEOUT;
            emit_res.expiry = 1'b1;
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register loads only when it is empty or being emptied.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_res_d   = emit_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tps_q        <= stp_pkg::TPS_RESET;
      presc_q      <= 8'd0;
      now_q        <= 64'd0;
      valid_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      rep_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tps_q        <= tps_d;
      presc_q      <= presc_d;
      now_q        <= now_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      rep_cnt_q    <= rep_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= command_i;
      tgt_q    <= target_slot_i;
      dur_q    <= duration_i;
      notify_q <= notify_on_expiry_i;
    end
    pend_slot_q <= pend_slot_d;
    out_res_q   <= out_res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_slot_o   = out_res_q.slot;
  assign success_o       = out_res_q.success;
  assign slot_status_o   = out_res_q.status;
  assign expiry_report_o = out_res_q.expiry;
  assign second_event_o  = out_res_q.second;
  assign last_result_o   = out_res_q.last;

  // Once allocated, a slot never returns to free.
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
    else $error("slot valid bit dropped");

  // The memory is written only at slots inside the pool.
  a_write_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((IdxW + 1)'(mem_waddr) < (IdxW + 1)'(NUM_SLOTS)))
    else $error("slot memory write beyond pool");

  // A held-back report is always counted.
  a_pend_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (rep_cnt_q != '0))
    else $error("pending report without count");

  // The number of reports of one check never exceeds the cap.
  a_rep_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q <= stp_pkg::CNT_W'(stp_pkg::MAX_RESULTS))
    else $error("expiry report count beyond cap");

  // No report is left pending when a new item can be taken.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !pend_valid_q)
    else $error("pending report while idle");

endmodule
